// ===== sv/rlp_pkg.sv =====
package rlp_pkg;

   // ELF ARM relocation type numbers
   typedef logic [7:0] op_type;

   localparam op_type OP_NONE     = 8'd0;
   localparam op_type OP_ABS32    = 8'd2;
   localparam op_type OP_REL32    = 8'd3;
   localparam op_type OP_THM_CALL = 8'd10;
   localparam op_type OP_CALL     = 8'd28;
   localparam op_type OP_JUMP24   = 8'd29;
   localparam op_type OP_TARGET1  = 8'd38;
   localparam op_type OP_V4BX     = 8'd40;
   localparam op_type OP_TARGET2  = 8'd41;
   localparam op_type OP_PREL31   = 8'd42;
   localparam op_type OP_MOVW_ABS = 8'd43;
   localparam op_type OP_MOVT_ABS = 8'd44;
   localparam op_type OP_THM_MOVW = 8'd47;
   localparam op_type OP_THM_MOVT = 8'd48;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNKNOWN   = 2'd1,
      ST_BAD_THUMB = 2'd2
   } status_type;

   // Thumb MOVW/MOVT encoding check
   localparam logic [31:0] THM_MOV_MASK = 32'h8000_FBF0;
   localparam logic [31:0] THM_MOVW_ENC = 32'h0000_F240;
   localparam logic [31:0] THM_MOVT_ENC = 32'h0000_F2C0;

   // ARM condition field value for the unconditional (BLX immediate) space
   localparam logic [3:0] COND_UNCOND = 4'hF;

   // Item after the address sums
   typedef struct packed {
      op_type      op;
      logic [31:0] word;
      logic [31:0] sabs;
      logic [31:0] place;
   } sum_item_type;

   // Item after the PC-relative difference
   typedef struct packed {
      op_type      op;
      logic [31:0] word;
      logic [31:0] sabs;
      logic [31:0] rel;
   } rel_item_type;

endpackage

// ===== sv/rlp_req_if.sv =====
interface rlp_req_if;
   import rlp_pkg::*;

   logic        valid;
   logic        ready;
   op_type      op;
   logic [31:0] orig_word;
   logic [31:0] place_offset;
   logic [31:0] symbol_seg_base;
   logic [31:0] symbol_offset;
   logic [31:0] place_seg_base;

   modport source (
      output valid, op, orig_word, place_offset, symbol_seg_base, symbol_offset,
             place_seg_base,
      input  ready
   );

   modport sink (
      input  valid, op, orig_word, place_offset, symbol_seg_base, symbol_offset,
             place_seg_base,
      output ready
   );

endinterface

// ===== sv/rlp_rsp_if.sv =====
interface rlp_rsp_if;
   import rlp_pkg::*;

   logic        valid;
   logic        ready;
   logic [31:0] patched_word;
   logic [1:0]  status;

   modport source (
      output valid, patched_word, status,
      input  ready
   );

   modport sink (
      input  valid, patched_word, status,
      output ready
   );

endinterface

// ===== sv/rlp_sum.sv =====
module rlp_sum (
   input  logic                 clock,
   input  logic                 reset,
   rlp_req_if.sink              req,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rlp_pkg::sum_item_type out_item
);
   import rlp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   sum_item_type item_ff;
   sum_item_type item_in;
   logic         load;

   // Take a new transfer when the stage is empty or drains this cycle
   assign req.ready = !valid_ff || out_ready;
   assign load      = req.valid && req.ready;
   assign valid_in  = req.ready ? req.valid : valid_ff;

   // Form the symbol address and the place address
   always_comb begin
      item_in.op    = req.op;
      item_in.word  = req.orig_word;
      item_in.sabs  = req.symbol_seg_base + req.symbol_offset;
      item_in.place = req.place_seg_base + req.place_offset;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload while stalled
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== sv/rlp_rel.sv =====
module rlp_rel (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rlp_pkg::sum_item_type in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output rlp_pkg::rel_item_type out_item
);
   import rlp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rel_item_type item_ff;
   rel_item_type item_in;
   logic         load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Subtract the place from the target (wraps modulo 2^32)
   always_comb begin
      item_in.op   = in_item.op;
      item_in.word = in_item.word;
      item_in.sabs = in_item.sabs;
      item_in.rel  = in_item.sabs - in_item.place;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== sv/rlp_patch.sv =====
module rlp_patch (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  rlp_pkg::rel_item_type in_item,
   rlp_rsp_if.source            rsp
);
   import rlp_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   logic [31:0] word_ff;
   logic [31:0] word_in;
   status_type  status_ff;
   status_type  status_in;
   logic        load;

   logic [31:0] w;
   logic [31:0] s;
   logic [31:0] d;
   logic        j1;
   logic        j2;
   logic [10:0] lo;
   logic        h_bit;

   assign in_ready = !valid_ff || rsp.ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign w = in_item.word;
   assign s = in_item.sabs;
   assign d = in_item.rel;

   // Thumb BL/BLX fields
   assign j1 = ~(d[24] ^ d[23]);
   assign j2 = ~(d[24] ^ d[22]);
   assign lo = {d[11:2], d[1] & w[28]};

   // BLX immediate: H bit takes bit 1 of the offset
   assign h_bit = (w[31:28] == COND_UNCOND) ? d[1] : w[24];

   // Repack the word by relocation type
   always_comb begin
      word_in   = w;
      status_in = ST_OK;
      unique case (in_item.op)
         OP_NONE, OP_V4BX: begin
            word_in = w;
         end
         OP_ABS32, OP_TARGET1: begin
            word_in = s;
         end
         OP_REL32, OP_TARGET2: begin
            word_in = d;
         end
         OP_THM_CALL: begin
            word_in = {w[31:30], j1, w[28], j2, lo, w[15:11], d[24], d[21:12]};
         end
         OP_CALL, OP_JUMP24: begin
            word_in = {w[31:25], h_bit, d[25:2]};
         end
         OP_PREL31: begin
            word_in = {w[31], d[30:0]};
         end
         OP_MOVW_ABS: begin
            word_in = {w[31:20], s[15:12], w[15:12], s[11:0]};
         end
         OP_MOVT_ABS: begin
            word_in = {w[31:20], s[31:28], w[15:12], s[27:16]};
         end
         OP_THM_MOVW: begin
            if ((w & THM_MOV_MASK) != THM_MOVW_ENC) begin
               status_in = ST_BAD_THUMB;
            end else begin
               word_in = {w[31], s[10:8], w[27:24], s[7:0], w[15:11], s[11], w[9:4],
                          s[15:12]};
            end
         end
         OP_THM_MOVT: begin
            if ((w & THM_MOV_MASK) != THM_MOVT_ENC) begin
               status_in = ST_BAD_THUMB;
            end else begin
               word_in = {w[31], s[26:24], w[27:24], s[23:16], w[15:11], s[27], w[9:4],
                          s[31:28]};
            end
         end
         default: begin
            status_in = ST_UNKNOWN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Output register: hold the result until the transfer
   always_ff @(posedge clock) begin
      if (load) begin
         word_ff   <= word_in;
         status_ff <= status_in;
      end
   end

   assign rsp.valid        = valid_ff;
   assign rsp.patched_word = word_ff;
   assign rsp.status       = status_ff;

endmodule

// ===== sv/arm_relocation_patch_unit.sv =====
// A request is registered in turn after the address sums, after the PC-relative subtract
// and after the field repack in the output register, which then offers the result.
// One relocation per cycle while responses are taken, as each stage forwards while
// the next drains. A stall on the response side holds every stage in place.
// Synchronous active-high reset clears the stage valid bits; data is not reset.
module arm_relocation_patch_unit (
   input  logic      clock,
   input  logic      reset,
   rlp_req_if.sink   req_chan,
   rlp_rsp_if.source rsp_chan
);
   import rlp_pkg::*;

   logic         sum_valid;
   logic         sum_ready;
   sum_item_type sum_item;
   logic         rel_valid;
   logic         rel_ready;
   rel_item_type rel_item;

   rlp_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_item  (sum_item)
   );

   rlp_rel u_rel (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_item   (sum_item),
      .out_valid (rel_valid),
      .out_ready (rel_ready),
      .out_item  (rel_item)
   );

   rlp_patch u_patch (
      .clock    (clock),
      .reset    (reset),
      .in_valid (rel_valid),
      .in_ready (rel_ready),
      .in_item  (rel_item),
      .rsp      (rsp_chan)
   );

   // An accepted request occupies the first stage next cycle
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> sum_valid)
      else $error("accepted request did not reach the sum stage");

   // A stalled first stage keeps its item
   a_sum_holds: assert property (@(posedge clock) disable iff (reset)
      sum_valid && !sum_ready |=> sum_valid && $stable(sum_item))
      else $error("sum stage lost or changed a stalled item");

   // A stalled second stage keeps its item
   a_rel_holds: assert property (@(posedge clock) disable iff (reset)
      rel_valid && !rel_ready |=> rel_valid && $stable(rel_item))
      else $error("rel stage lost or changed a stalled item");

   // Reset empties every stage
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !sum_valid && !rel_valid && !rsp_chan.valid)
      else $error("pipeline not empty after reset");

endmodule
